/* design/sbf_pkg.sv */
package sbf_pkg;

  localparam int unsigned PosW         = 7;
  localparam int unsigned SymW         = 8;
  localparam int unsigned CntW         = 32;
  localparam int unsigned MissW        = 4;
  localparam int unsigned BlockFramesDef = 98;
  localparam logic [MissW-1:0] MissLimitRst = 4'd4;

  typedef struct packed {
    logic            sync0;
    logic            sync1;
    logic [SymW-1:0] symbol;
  } frame_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            kept;
    logic            done;
    logic            first;
    logic            drop;
    logic [SymW-1:0] symbol;
    logic [CntW-1:0] blocks;
    logic [CntW-1:0] poor;
    logic [CntW-1:0] lost;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (&v) ? v : v + CntW'(1);
  endfunction

endpackage

/* design/subcode_block_framer.sv */
// Subcode block framer: takes one frame request per clock on the slave side and returns one
// result per frame on the master side, through an input register and then the result
// register. The block hunts for SYNC0 then SYNC1, groups BLOCK_FRAMES frames into
// a block, checks the sync of each later block and drops the partial block once
// miss_limit consecutive block syncs are bad. Throughput is one frame per cycle while
// m_axis_tready stays high; s_axis_tready follows m_axis_tready through the two register
// stages. miss_limit should be written only while no frame is in flight.
module subcode_block_framer import sbf_pkg::*; #(
  parameter int unsigned BLOCK_FRAMES = BlockFramesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [MissW-1:0] cfg_wr_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // subcode_symbol
  input  logic [1:0]       s_axis_tuser,  // sync0_mark, sync1_mark
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // frame_position, symbol_out, blocks_total, poor_sync_total, lock_lost_total, zero pad
  output logic [111:0]     m_axis_tdata,
  output logic [2:0]       m_axis_tuser,  // frame_kept, first_after_lock, drop_pending
  output logic             m_axis_tlast   // block_done
);

  frame_t  in_frame, reg_frame;
  logic    reg_valid, advance;
  result_t result;

  assign in_frame.sync0  = s_axis_tuser[0];
  assign in_frame.sync1  = s_axis_tuser[1];
  assign in_frame.symbol = s_axis_tdata;

  sbf_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .frame_i   (in_frame),
    .valid_o   (reg_valid),
    .advance_i (advance),
    .frame_o   (reg_frame)
  );

  sbf_core #(
    .BLOCK_FRAMES (BLOCK_FRAMES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_wr_en_i),
    .cfg_wdata_i (cfg_wr_data_i),
    .in_valid_i  (reg_valid),
    .frame_i     (reg_frame),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {1'b0, result.lost, result.poor, result.blocks, result.symbol,
                         result.position};
  assign m_axis_tuser = {result.drop, result.first, result.kept};
  assign m_axis_tlast = result.done;

endmodule

/* design/sbf_in_stage.sv */
module sbf_in_stage import sbf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  frame_t frame_i,
  output logic   valid_o,
  input  logic   advance_i,
  output frame_t frame_o
);

  logic   valid_q;
  frame_t frame_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign frame_o = frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      frame_q <= frame_i;
    end
  end

endmodule

/* design/sbf_core.sv */
module sbf_core import sbf_pkg::*; #(
  parameter int unsigned BLOCK_FRAMES = BlockFramesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MissW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  frame_t           frame_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          result_o
);

  typedef enum logic [1:0] {
    PhHunt0,
    PhHunt1,
    PhFirst,
    PhNext
  } phase_e;

  localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_FRAMES - 1);
  localparam logic [MissW-1:0] MissMax = {MissW{1'b1}};

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  fill_q, fill_d;
  logic             head_q, head_d;
  logic [MissW-1:0] miss_q, miss_d;
  logic [MissW-1:0] limit_q;
  logic [CntW-1:0]  blocks_q, blocks_d;
  logic [CntW-1:0]  poor_q, poor_d;
  logic [CntW-1:0]  lost_q, lost_d;
  logic             out_valid_q;
  result_t          result_q, result_d;

  assign advance_o   = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    logic hunt;
    logic lost;
    logic [MissW-1:0] miss_inc;
    phase_d  = phase_q;
    fill_d   = fill_q;
    head_d   = head_q;
    miss_d   = miss_q;
    blocks_d = blocks_q;
    poor_d   = poor_q;
    lost_d   = lost_q;
    hunt     = 1'b0;
    lost     = 1'b0;
    miss_inc = (miss_q == MissMax) ? miss_q : miss_q + MissW'(1);
    result_d = '0;
    result_d.symbol = frame_i.symbol;
    case (phase_q)
      PhHunt0: begin
        hunt = 1'b1;
      end
      PhHunt1: begin
        if (frame_i.sync1) begin
          result_d.position = PosW'(1);
          result_d.kept     = 1'b1;
          fill_d            = PosW'(2);
          phase_d           = PhFirst;
        end else begin
          result_d.drop = 1'b1;
          fill_d        = '0;
          phase_d       = PhHunt0;
        end
      end
      PhFirst: begin
        result_d.position = fill_q;
        result_d.kept     = 1'b1;
        if (fill_q == LastPos) begin
          result_d.done  = 1'b1;
          result_d.first = 1'b1;
          blocks_d       = sat_inc(blocks_q);
          fill_d         = '0;
          phase_d        = PhNext;
        end else begin
          fill_d = fill_q + PosW'(1);
        end
      end
      PhNext: begin
        result_d.position = fill_q;
        result_d.kept     = 1'b1;
        if (fill_q == '0) begin
          head_d = frame_i.sync0;
        end
        if (fill_q == PosW'(1)) begin
          if (head_q && frame_i.sync1) begin
            miss_d = '0;
          end else begin
            miss_d = miss_inc;
            poor_d = sat_inc(poor_q);
            if (miss_inc >= limit_q) begin
              miss_d = '0;
              lost   = 1'b1;
            end
          end
        end
        if (lost) begin
          lost_d            = sat_inc(lost_q);
          result_d.drop     = 1'b1;
          result_d.kept     = 1'b0;
          result_d.position = '0;
          fill_d            = '0;
          phase_d           = PhHunt0;
          hunt              = 1'b1;
        end else if (fill_q == LastPos) begin
          result_d.done = 1'b1;
          blocks_d      = sat_inc(blocks_q);
          fill_d        = '0;
        end else begin
          fill_d = fill_q + PosW'(1);
        end
      end
      default: begin
        hunt = 1'b1;
      end
    endcase
    if (hunt) begin
      if (frame_i.sync0) begin
        result_d.position = '0;
        result_d.kept     = 1'b1;
        head_d            = 1'b1;
        fill_d            = PosW'(1);
        phase_d           = PhHunt1;
      end else begin
        fill_d  = '0;
        phase_d = PhHunt0;
      end
    end
    result_d.blocks = blocks_d;
    result_d.poor   = poor_d;
    result_d.lost   = lost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt0;
      fill_q      <= '0;
      head_q      <= 1'b0;
      miss_q      <= '0;
      limit_q     <= MissLimitRst;
      blocks_q    <= '0;
      poor_q      <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (advance_o) begin
        phase_q     <= phase_d;
        fill_q      <= fill_d;
        head_q      <= head_d;
        miss_q      <= miss_d;
        blocks_q    <= blocks_d;
        poor_q      <= poor_d;
        lost_q      <= lost_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_d;
    end
  end

  // A block position never runs past the last frame of a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= LastPos)
    else $error("fill count beyond block length");

  // While waiting for SYNC1 exactly the SYNC0 frame is buffered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHunt1 |-> fill_q == PosW'(1) && head_q)
    else $error("hunt for SYNC1 without a buffered SYNC0 frame");

  // The first-after-lock mark only comes with a completed block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.first |-> result_q.done && result_q.blocks != '0)
    else $error("first-after-lock mark without a completed block");

  // A loss of sync is counted in the same request that reports the drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && phase_q == PhNext && phase_d == PhHunt0 |-> result_d.drop)
    else $error("sync loss without drop mark");

endmodule

/* verif/subcode_block_framer_tb.sv */
module subcode_block_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbf_pkg::*;

  localparam int Frames = BlockFramesDef;
  localparam int RandomPerPhase = 90;
  localparam int ReportCap = 40;

  typedef enum logic [1:0] {
    HuntSync0,
    HuntSync1,
    FirstBlock,
    LaterBlock
  } framer_phase_e;

  typedef struct packed {
    frame_t  frame;
    logic    typed;
    result_t want;
  } probe_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_wr_en_i;
  logic [MissW-1:0] cfg_wr_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [111:0]     m_axis_tdata;
  logic [2:0]       m_axis_tuser;
  logic             m_axis_tlast;

  framer_phase_e    phase_q;
  int               fill_q;
  logic             head_sync0_q;
  logic [MissW-1:0] miss_run_q;
  logic [MissW-1:0] miss_limit_q;
  logic [CntW-1:0]  blocks_q;
  logic [CntW-1:0]  poor_q;
  logic [CntW-1:0]  lost_q;

  result_t expected_frames[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      disc_pos;
  int      sync_fault_pct;
  probe_t  directed_rows[12];
  int      miss_settings[5] = '{1, 0, 2, 15, 4};

  subcode_block_framer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [CntW-1:0] count_up(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + CntW'(1);
  endfunction

  function automatic result_t frame_outcome(input frame_t f);
    result_t r;
    logic    hunt;
    logic    lost;
    r = '0;
    hunt = 1'b0;
    lost = 1'b0;
    r.symbol = f.symbol;
    case (phase_q)
      HuntSync0: begin
        hunt = 1'b1;
      end
      HuntSync1: begin
        if (f.sync1) begin
          r.position = 7'd1;
          r.kept = 1'b1;
          fill_q = 2;
          phase_q = FirstBlock;
        end else begin
          r.drop = 1'b1;
          fill_q = 0;
          phase_q = HuntSync0;
        end
      end
      FirstBlock: begin
        r.position = PosW'(fill_q);
        r.kept = 1'b1;
        if (fill_q + 1 >= Frames) begin
          r.done = 1'b1;
          r.first = 1'b1;
          blocks_q = count_up(blocks_q);
          fill_q = 0;
          phase_q = LaterBlock;
        end else begin
          fill_q = fill_q + 1;
        end
      end
      default: begin
        r.position = PosW'(fill_q);
        r.kept = 1'b1;
        if (fill_q == 0) head_sync0_q = f.sync0;
        if (fill_q == 1) begin
          if (head_sync0_q && f.sync1) begin
            miss_run_q = '0;
          end else begin
            if (miss_run_q != '1) miss_run_q = miss_run_q + MissW'(1);
            poor_q = count_up(poor_q);
            if (miss_run_q >= miss_limit_q) begin
              miss_run_q = '0;
              lost = 1'b1;
            end
          end
        end
        if (lost) begin
          lost_q = count_up(lost_q);
          r.drop = 1'b1;
          r.kept = 1'b0;
          r.position = '0;
          fill_q = 0;
          phase_q = HuntSync0;
          hunt = 1'b1;
        end else if (fill_q + 1 >= Frames) begin
          r.done = 1'b1;
          blocks_q = count_up(blocks_q);
          fill_q = 0;
        end else begin
          fill_q = fill_q + 1;
        end
      end
    endcase
    if (hunt) begin
      if (f.sync0) begin
        r.position = '0;
        r.kept = 1'b1;
        head_sync0_q = 1'b1;
        fill_q = 1;
        phase_q = HuntSync1;
      end else begin
        fill_q = 0;
        phase_q = HuntSync0;
      end
    end
    r.blocks = blocks_q;
    r.poor = poor_q;
    r.lost = lost_q;
    return r;
  endfunction

  function automatic result_t typed_out(input logic [PosW-1:0] pos, input logic kept,
                                        input logic drop, input logic [SymW-1:0] sym);
    result_t r;
    r = '0;
    r.position = pos;
    r.kept = kept;
    r.drop = drop;
    r.symbol = sym;
    return r;
  endfunction

  // Frames follow the disc's block grid, with sync faults, noise and rare slips.
  function automatic frame_t next_disc_frame();
    frame_t f;
    f.symbol = SymW'($urandom_range(255));
    if ($urandom_range(99) < 3) begin
      f.sync0 = 1'($urandom_range(1));
      f.sync1 = 1'($urandom_range(1));
    end else begin
      f.sync0 = (disc_pos == 0);
      f.sync1 = (disc_pos == 1);
      if (disc_pos < 2 && $urandom_range(99) < sync_fault_pct) begin
        f.sync0 = 1'($urandom_range(1));
        f.sync1 = 1'($urandom_range(1));
      end
    end
    if ($urandom_range(999) < 3) begin
      disc_pos = $urandom_range(Frames - 1);
    end else begin
      disc_pos = (disc_pos + 1) % Frames;
    end
    return f;
  endfunction

  task automatic check_field(input string name, input logic [CntW-1:0] want,
                             input logic [CntW-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportCap) begin
        $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  task automatic send_frame(input frame_t f, input logic typed, input result_t want);
    result_t outcome;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= f.symbol;
    s_axis_tuser <= {f.sync1, f.sync0};
    do @(posedge clk_i); while (!s_axis_tready);
    outcome = frame_outcome(f);
    expected_frames.push_back(typed ? want : outcome);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_frames.size() != 0);
  endtask

  task automatic set_miss_limit(input logic [MissW-1:0] v);
    drain_results();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    miss_limit_q = v;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 28;
        recv_idle_pct = 49;
      end
      1: begin
        send_idle_pct = 49;
        recv_idle_pct = 28;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("subcode_block_framer: mismatch");
    $finish;
  end

  initial begin
    result_t got;
    result_t want;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.position = m_axis_tdata[PosW-1:0];
        got.symbol = m_axis_tdata[PosW +: SymW];
        got.blocks = m_axis_tdata[PosW + SymW +: CntW];
        got.poor = m_axis_tdata[PosW + SymW + CntW +: CntW];
        got.lost = m_axis_tdata[PosW + SymW + 2 * CntW +: CntW];
        got.kept = m_axis_tuser[0];
        got.first = m_axis_tuser[1];
        got.drop = m_axis_tuser[2];
        got.done = m_axis_tlast;
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap) begin
            $display("%0t unexpected result expected none actual %p", $time, got);
          end
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_position", CntW'(want.position), CntW'(got.position));
          check_field("frame_kept", CntW'(want.kept), CntW'(got.kept));
          check_field("block_done", CntW'(want.done), CntW'(got.done));
          check_field("first_after_lock", CntW'(want.first), CntW'(got.first));
          check_field("drop_pending", CntW'(want.drop), CntW'(got.drop));
          check_field("symbol_out", CntW'(want.symbol), CntW'(got.symbol));
          check_field("blocks_total", want.blocks, got.blocks);
          check_field("poor_sync_total", want.poor, got.poor);
          check_field("lock_lost_total", want.lost, got.lost);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_wr_en_i <= 1'b0;
    cfg_wr_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    mismatches = 0;
    disc_pos = 0;
    sync_fault_pct = 35;
    phase_q = HuntSync0;
    fill_q = 0;
    head_sync0_q = 1'b0;
    miss_run_q = '0;
    miss_limit_q = MissLimitRst;
    blocks_q = '0;
    poor_q = '0;
    lost_q = '0;
    set_idling(0);

    // Hunting rows: a lone SYNC1, a SYNC0 without SYNC1 behind it, both flags in one
    // frame, and a SYNC0 that breaks the SYNC1 hunt without becoming a candidate.
    directed_rows = '{
      '{'{1'b0, 1'b0, 8'h00}, 1'b1, typed_out(7'd0, 1'b0, 1'b0, 8'h00)},
      '{'{1'b0, 1'b1, 8'hFF}, 1'b1, typed_out(7'd0, 1'b0, 1'b0, 8'hFF)},
      '{'{1'b1, 1'b0, 8'h5A}, 1'b1, typed_out(7'd0, 1'b1, 1'b0, 8'h5A)},
      '{'{1'b0, 1'b0, 8'hA5}, 1'b1, typed_out(7'd0, 1'b0, 1'b1, 8'hA5)},
      '{'{1'b1, 1'b1, 8'h01}, 1'b1, typed_out(7'd0, 1'b1, 1'b0, 8'h01)},
      '{'{1'b1, 1'b0, 8'h80}, 1'b1, typed_out(7'd0, 1'b0, 1'b1, 8'h80)},
      '{'{1'b1, 1'b0, 8'h7F}, 1'b1, typed_out(7'd0, 1'b1, 1'b0, 8'h7F)},
      '{'{1'b1, 1'b1, 8'hC3}, 1'b1, typed_out(7'd1, 1'b1, 1'b0, 8'hC3)},
      '{'{1'b0, 1'b0, 8'h10}, 1'b0, result_t'('0)},
      '{'{1'b1, 1'b1, 8'hEF}, 1'b0, result_t'('0)},
      '{'{1'b1, 1'b0, 8'h33}, 1'b0, result_t'('0)},
      '{'{1'b0, 1'b1, 8'hCC}, 1'b0, result_t'('0)}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 5; p++) begin
      set_miss_limit(MissW'(miss_settings[p]));
      set_idling(p * 3 / 5);
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (p == 1 && n == RandomPerPhase / 2) drain_results();
        send_frame(next_disc_frame(), 1'b0, result_t'('0));
      end
    end

    set_idling(2);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("subcode_block_framer: match");
    end else begin
      $display("subcode_block_framer: mismatch");
    end
    $finish;
  end

endmodule
